@@ rtl/core/spcf_pkg.sv @@
package spcf_pkg;

  // Row geometry: every row number wraps at MAX_ROWS.
  localparam int MAX_ROWS  = 4096;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int SEEN_W    = ROW_W + 1;

  // Filter window.
  localparam int PIX_W     = 8;
  localparam int TAPS      = 15;
  localparam int HALF_TAPS = 7;
  localparam int KERNEL [TAPS] = '{2, 7, 20, 44, 80, 121, 155, 168,
                                   155, 121, 80, 44, 20, 7, 2};

  // Arithmetic widths of one window.
  localparam int RESP_W    = 19;             // 1026 * 255 fits in 19 bits
  localparam int GRAY_W    = 12;             // 15 * 255 fits in 12 bits
  localparam int TSUM_W    = 15;             // sum of t * pixel, t up to 14
  localparam int WSUM_W    = ROW_W + GRAY_W; // row-weighted gray sum
  localparam int CENT_W    = ROW_W + 4;      // Q.4 centroid
  localparam int DIV_CNT_W = $clog2(CENT_W);

  // Row queue between the front and the back.
  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = QPTR_W + 1;

  // Stream and configuration port widths.
  localparam int OUT_W     = ((2 * ROW_W + 2 * CENT_W + 7) / 8) * 8;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  // Register index, taken from address bit 2.
  localparam logic REG_START_ROW = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  localparam logic [ROW_W-1:0] START_ROW_RESET = ROW_W'(480);
  localparam logic [ROW_W-1:0] ROW_COUNT_RESET = ROW_W'(120);

  // One examined window center as it travels to the tracker.
  typedef struct packed {
    logic [RESP_W-1:0] resp;
    logic [GRAY_W-1:0] gray;
    logic [WSUM_W-1:0] wsum;
    logic [ROW_W-1:0]  center;
    logic              last;   // last center of the column
    logic              clr;    // first center after a column start
  } row_item_t;

  typedef enum logic [1:0] {
    B_TRACK,
    B_START,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

@@ rtl/core/spcf_front.sv @@
module spcf_front import spcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  pixel,
  input  logic              column_first,
  input  logic [ROW_W-1:0]  start_row,
  input  logic [ROW_W-1:0]  row_count,
  input  logic [QCNT_W-1:0] q_count,
  output logic              push,
  output row_item_t         push_item
);

  logic [PIX_W-1:0]  window_r [TAPS];
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic              clr_pend_r, clr_pend_nxt;

  logic              vld0_r, vld1_r, vld2_r;
  logic [ROW_W-1:0]  center0_r, center1_r, center2_r;
  logic [ROW_W-1:0]  base0_r, base1_r;
  logic              last0_r, last1_r, last2_r;
  logic              clr0_r, clr1_r, clr2_r;

  logic [RESP_W-1:0] resp_a, resp_b, resp_a1_r, resp_b1_r, resp2_r;
  logic [GRAY_W-1:0] gray_s, gray1_r, gray2_r;
  logic [TSUM_W-1:0] tsum_a, tsum_b, tsum_a1_r, tsum_b1_r, tsum2_r;
  logic [GRAY_W-1:0] wrap_s, wrap1_r, wrap2_r;
  logic [WSUM_W-1:0] prod2_r;

  logic              acc, take, row_hit;
  logic [SEEN_W-1:0] seen_base, seen_new, limit;
  logic [ROW_W-1:0]  center_new;
  logic [QCNT_W:0]   in_flight;

  // Accept only while the queue has room for every row already in flight.
  assign in_flight = {1'b0, q_count} + (QCNT_W+1)'(vld0_r) + (QCNT_W+1)'(vld1_r)
                   + (QCNT_W+1)'(vld2_r);
  assign in_ready  = in_flight < (QCNT_W+1)'(QDEPTH);
  assign acc       = in_valid && in_ready;

  // Column position and the window center that the new pixel completes.
  assign limit      = SEEN_W'(2 * HALF_TAPS) + SEEN_W'(row_count);
  assign seen_base  = column_first ? '0 : seen_r;
  assign take       = acc && (seen_base < limit);
  assign seen_new   = seen_base + SEEN_W'(1);
  assign row_hit    = take && (seen_new >= SEEN_W'(TAPS));
  assign center_new = start_row + ROW_W'(seen_new - SEEN_W'(TAPS));

  always_comb begin
    seen_nxt     = seen_r;
    clr_pend_nxt = clr_pend_r;
    if (acc) begin
      seen_nxt = take ? seen_new : seen_base;
      if (row_hit) begin
        clr_pend_nxt = 1'b0;
      end else if (column_first) begin
        clr_pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      clr_pend_r <= 1'b1;
      vld0_r     <= 1'b0;
      vld1_r     <= 1'b0;
      vld2_r     <= 1'b0;
    end else begin
      seen_r     <= seen_nxt;
      clr_pend_r <= clr_pend_nxt;
      vld0_r     <= row_hit;
      vld1_r     <= vld0_r;
      vld2_r     <= vld1_r;
    end
  end

  // Pixel window, newest pixel at the top.
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        window_r[i] <= window_r[i+1];
      end
      window_r[TAPS-1] <= pixel;
    end
  end

  // Row bookkeeping that travels beside the window.
  always_ff @(posedge clk) begin
    if (row_hit) begin
      center0_r <= center_new;
      base0_r   <= center_new - ROW_W'(HALF_TAPS);
      last0_r   <= (seen_new == limit);
      clr0_r    <= clr_pend_r || column_first;
    end
  end

  // Partial sums of the window: filter response, gray sum, tap-weighted sum
  // and the gray sum of the taps whose row wraps past the last row.
  always_comb begin
    logic [PIX_W:0] pair;
    logic [ROW_W:0] row_sum;
    resp_a = '0;
    resp_b = '0;
    gray_s = '0;
    tsum_a = '0;
    tsum_b = '0;
    wrap_s = '0;
    for (int t = 0; t < HALF_TAPS; t++) begin
      pair = {1'b0, window_r[t]} + {1'b0, window_r[TAPS-1-t]};
      if (t < HALF_TAPS / 2 + 1) begin
        resp_a = resp_a + RESP_W'(KERNEL[t]) * RESP_W'(pair);
      end else begin
        resp_b = resp_b + RESP_W'(KERNEL[t]) * RESP_W'(pair);
      end
    end
    resp_b = resp_b + RESP_W'(KERNEL[HALF_TAPS]) * RESP_W'(window_r[HALF_TAPS]);
    for (int t = 0; t < TAPS; t++) begin
      row_sum = {1'b0, base0_r} + (ROW_W+1)'(t);
      gray_s  = gray_s + GRAY_W'(window_r[t]);
      if (row_sum[ROW_W]) begin
        wrap_s = wrap_s + GRAY_W'(window_r[t]);
      end
      if (t <= HALF_TAPS) begin
        tsum_a = tsum_a + TSUM_W'(t) * TSUM_W'(window_r[t]);
      end else begin
        tsum_b = tsum_b + TSUM_W'(t) * TSUM_W'(window_r[t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    resp_a1_r <= resp_a;
    resp_b1_r <= resp_b;
    gray1_r   <= gray_s;
    tsum_a1_r <= tsum_a;
    tsum_b1_r <= tsum_b;
    wrap1_r   <= wrap_s;
    base1_r   <= base0_r;
    center1_r <= center0_r;
    last1_r   <= last0_r;
    clr1_r    <= clr0_r;
  end

  // Final sums and the base row times the gray sum.
  always_ff @(posedge clk) begin
    resp2_r   <= resp_a1_r + resp_b1_r;
    tsum2_r   <= tsum_a1_r + tsum_b1_r;
    prod2_r   <= WSUM_W'(base1_r) * WSUM_W'(gray1_r);
    gray2_r   <= gray1_r;
    wrap2_r   <= wrap1_r;
    center2_r <= center1_r;
    last2_r   <= last1_r;
    clr2_r    <= clr1_r;
  end

  // Weighted sum: base * gray + sum(t * pixel), less one full row span
  // for every wrapped tap.
  assign push             = vld2_r;
  assign push_item.resp   = resp2_r;
  assign push_item.gray   = gray2_r;
  assign push_item.wsum   = prod2_r + WSUM_W'(tsum2_r) - (WSUM_W'(wrap2_r) << ROW_W);
  assign push_item.center = center2_r;
  assign push_item.last   = last2_r;
  assign push_item.clr    = clr2_r;

endmodule

@@ rtl/core/spcf_fifo.sv @@
module spcf_fifo import spcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  row_item_t         push_item,
  input  logic              pop,
  output row_item_t         head_item,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  row_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head_item = mem_r[rd_ptr_r];
  assign empty     = (count_r == '0);
  assign count     = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  // The front's credit check must keep the queue from overflowing.
  assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r < QCNT_W'(QDEPTH))
    else $error("row queue overflow");

  // The back only takes an item that is there.
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("row queue underflow");
`endif

endmodule

@@ rtl/core/spcf_div.sv @@
module spcf_div import spcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WSUM_W-1:0] dividend,
  input  logic [GRAY_W-1:0] divisor,
  output logic              busy,
  output logic [CENT_W-1:0] quotient
);

  // Restoring division of dividend * 16 by divisor, one quotient bit a cycle.
  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [GRAY_W-1:0]    rem_r;
  logic [GRAY_W-1:0]    den_r;
  logic [CENT_W-1:0]    low_r;
  logic [CENT_W-1:0]    quo_r;
  logic [GRAY_W:0]      trial;
  logic [GRAY_W:0]      diff;
  logic                 fits;

  assign trial = {rem_r, low_r[CENT_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= DIV_CNT_W'(CENT_W - 1);
      rem_r <= dividend[WSUM_W-1:ROW_W];
      low_r <= {dividend[ROW_W-1:0], 4'b0000};
      den_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
      rem_r <= fits ? diff[GRAY_W-1:0] : trial[GRAY_W-1:0];
      low_r <= {low_r[CENT_W-2:0], 1'b0};
      quo_r <= {quo_r[CENT_W-2:0], fits};
    end
  end

  // A window without any gray value has centroid zero.
  assign busy     = busy_r;
  assign quotient = (den_r == '0) ? '0 : quo_r;

endmodule

@@ rtl/core/spcf_back.sv @@
module spcf_back import spcf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  row_item_t        head_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  back_state_t       state_r, state_nxt;

  logic [RESP_W-1:0] best_resp_r, second_resp_r;
  logic [ROW_W-1:0]  best_center_r, second_center_r;
  logic [WSUM_W-1:0] best_wsum_r, second_wsum_r;
  logic [GRAY_W-1:0] best_gray_r, second_gray_r;

  logic [RESP_W-1:0] cur_best, cur_second, best_after;
  logic              take_best, take_second;

  logic [ROW_W-1:0]  snap_best_r, snap_second_r;
  logic              div_start, best_busy, second_busy;
  logic [CENT_W-1:0] best_quo, second_quo;

  logic              out_vld_r, out_load;
  logic [OUT_W-1:0]  out_data_r;

  // Tracking rule: a larger response replaces the peak; a response below the
  // updated peak and above the second replaces the second.
  assign cur_best    = head_item.clr ? '0 : best_resp_r;
  assign cur_second  = head_item.clr ? '0 : second_resp_r;
  assign take_best   = head_item.resp > cur_best;
  assign best_after  = take_best ? head_item.resp : cur_best;
  assign take_second = (head_item.resp < best_after) && (head_item.resp > cur_second);

  // Sequencer: track rows, then run both centroid divisions, then hand over.
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      B_TRACK: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (head_item.last) begin
            state_nxt = B_START;
          end
        end
      end
      B_START: begin
        div_start = 1'b1;
        state_nxt = B_DIV;
      end
      B_DIV: begin
        if (!best_busy && !second_busy) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_vld_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = B_TRACK;
        end
      end
      default: begin
        state_nxt = B_TRACK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_TRACK;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Tracker registers; a column start clears whatever the new row does not replace.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_resp_r     <= '0;
      second_resp_r   <= '0;
      best_center_r   <= '0;
      second_center_r <= '0;
      best_wsum_r     <= '0;
      second_wsum_r   <= '0;
      best_gray_r     <= '0;
      second_gray_r   <= '0;
    end else if (pop) begin
      if (take_best) begin
        best_resp_r   <= head_item.resp;
        best_center_r <= head_item.center;
        best_wsum_r   <= head_item.wsum;
        best_gray_r   <= head_item.gray;
      end else if (head_item.clr) begin
        best_resp_r   <= '0;
        best_center_r <= '0;
        best_wsum_r   <= '0;
        best_gray_r   <= '0;
      end
      if (take_second) begin
        second_resp_r   <= head_item.resp;
        second_center_r <= head_item.center;
        second_wsum_r   <= head_item.wsum;
        second_gray_r   <= head_item.gray;
      end else if (head_item.clr) begin
        second_resp_r   <= '0;
        second_center_r <= '0;
        second_wsum_r   <= '0;
        second_gray_r   <= '0;
      end
    end
  end

  // Centers are held while the divisions run.
  always_ff @(posedge clk) begin
    if (div_start) begin
      snap_best_r   <= best_center_r;
      snap_second_r <= second_center_r;
    end
  end

  spcf_div u_div_best (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (best_wsum_r),
    .divisor  (best_gray_r),
    .busy     (best_busy),
    .quotient (best_quo)
  );

  spcf_div u_div_second (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (second_wsum_r),
    .divisor  (second_gray_r),
    .busy     (second_busy),
    .quotient (second_quo)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= OUT_W'({second_quo, best_quo, snap_second_r, snap_best_r});
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The second response never rises above the peak.
  assert property (@(posedge clk) disable iff (!rst_n)
    second_resp_r <= best_resp_r)
    else $error("second response above peak");

  // A finished result is never dropped while the previous one waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_vld_r || out_ready)
    else $error("result overwritten");

  // The dividers are never restarted in the middle of a column result.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !best_busy && !second_busy)
    else $error("divider restarted while busy");
`endif

endmodule

@@ rtl/core/stripe_peak_centroid_finder.sv @@
// After its last search-row pixel a column result passes the front pipeline, the row
// queue, the tracker, the two centroid divisions and the output register. Throughput:
// one pixel per cycle within a column while the row queue has room; the back pops no
// row while it divides and hands over, so back-to-back columns fill the queue and stall.
// Reset: synchronous, active low; clears the column counter, queue and tracker,
// and loads search_start_row = 480 and search_row_count = 120.
module stripe_peak_centroid_finder import spcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Pixel stream.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,   // [7:0] pixel
  input  logic              in_tuser,   // [0] column_first
  // Result stream.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // peak_row, second_row, peak_centroid,
                                        // second_centroid from bit 0 up
  // Configuration port.
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [ROW_W-1:0]  start_row_r, row_count_r;
  logic              cfg_wr;
  logic              reg_sel;

  logic              push, pop, q_empty;
  row_item_t         push_item, head_item;
  logic [QCNT_W-1:0] q_count;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_row_r <= START_ROW_RESET;
      row_count_r <= ROW_COUNT_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == REG_START_ROW) begin
        start_row_r <= cfg_pwdata[ROW_W-1:0];
      end else begin
        row_count_r <= cfg_pwdata[ROW_W-1:0];
      end
    end
  end

  assign cfg_prdata = (reg_sel == REG_ROW_COUNT) ? CFG_DW'(row_count_r)
                                                 : CFG_DW'(start_row_r);

  spcf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .pixel        (in_tdata),
    .column_first (in_tuser),
    .start_row    (start_row_r),
    .row_count    (row_count_r),
    .q_count      (q_count),
    .push         (push),
    .push_item    (push_item)
  );

  spcf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .empty     (q_empty),
    .count     (q_count)
  );

  spcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

@@ sim/tb_stripe_peak_centroid_finder.sv @@
`timescale 1ns / 100ps

module tb_stripe_peak_centroid_finder;
  import spcf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int HOLD_CYCLES    = 600;
  localparam int RANDOM_ITEMS   = 750;
  localparam int MAX_REPORTS    = 10;

  // One column result, peak_row in the lowest bits.
  typedef struct packed {
    logic [CENT_W-1:0] second_centroid;
    logic [CENT_W-1:0] peak_centroid;
    logic [ROW_W-1:0]  second_row;
    logic [ROW_W-1:0]  peak_row;
  } column_result_t;

  typedef enum int {
    COL_STRIPE,
    COL_NOISE,
    COL_FLAT,
    COL_DARK,
    COL_BRIGHT
  } column_kind_t;

  // Predicts the peak and second rows and centroids of each column and checks the results.
  class column_scoreboard;
    logic [ROW_W-1:0] start_row;
    logic [ROW_W-1:0] row_count;
    logic [PIX_W-1:0] window [TAPS];
    int unsigned seen;
    int unsigned best_resp, best_center, best_wsum, best_gray;
    int unsigned second_resp, second_center, second_wsum, second_gray;
    column_result_t expected_columns[$];
    int errors;

    function new();
      start_row = START_ROW_RESET;
      row_count = ROW_COUNT_RESET;
      errors = 0;
      clear_column();
    endfunction

    function void clear_column();
      seen = 0;
      best_resp = 0;
      best_center = 0;
      best_wsum = 0;
      best_gray = 0;
      second_resp = 0;
      second_center = 0;
      second_wsum = 0;
      second_gray = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_DW-1:0] value);
      if (idx == REG_START_ROW) begin
        start_row = value[ROW_W-1:0];
      end else begin
        row_count = value[ROW_W-1:0];
      end
    endfunction

    function logic [CENT_W-1:0] centroid_q4(int unsigned wsum, int unsigned gray);
      longint unsigned scaled;
      if (gray == 0) begin
        return '0;
      end
      scaled = (longint'(wsum) * 16) / gray;
      return scaled[CENT_W-1:0];
    endfunction

    // Takes one accepted pixel and queues a column result when one is due.
    function void note_pixel(logic [PIX_W-1:0] pix, logic first);
      int unsigned limit, center, resp, gray, wsum, row;
      column_result_t r;
      if (first) begin
        clear_column();
      end
      limit = 2 * HALF_TAPS + row_count;
      if (seen >= limit) begin
        return;
      end
      for (int t = 0; t < TAPS - 1; t++) begin
        window[t] = window[t + 1];
      end
      window[TAPS-1] = pix;
      seen++;
      if (seen < TAPS) begin
        return;
      end

      // Filter the window and form the gray sums; rows wrap at MAX_ROWS.
      center = (start_row + seen - TAPS) % MAX_ROWS;
      resp = 0;
      gray = 0;
      wsum = 0;
      for (int t = 0; t < TAPS; t++) begin
        row = (center + t + MAX_ROWS - HALF_TAPS) % MAX_ROWS;
        resp += KERNEL[t] * window[t];
        gray += window[t];
        wsum += window[t] * row;
      end

      // A new best does not demote the old one; ties change nothing.
      if (resp > best_resp) begin
        best_resp = resp;
        best_center = center;
        best_wsum = wsum;
        best_gray = gray;
      end
      if (resp < best_resp && resp > second_resp) begin
        second_resp = resp;
        second_center = center;
        second_wsum = wsum;
        second_gray = gray;
      end

      if (seen != limit) begin
        return;
      end
      r.peak_row = best_center[ROW_W-1:0];
      r.second_row = second_center[ROW_W-1:0];
      r.peak_centroid = centroid_q4(best_wsum, best_gray);
      r.second_centroid = centroid_q4(second_wsum, second_gray);
      expected_columns.insert(expected_columns.size(), r);
    endfunction

    // Compares one accepted result with the oldest expected column.
    function void check_result(logic [OUT_W-1:0] data);
      column_result_t got;
      column_result_t want;
      got = data;
      if (expected_columns.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected column result %h at %0t", data, $realtime);
        end
        return;
      end
      want = expected_columns.pop_front();
      if (got.peak_row !== want.peak_row || got.second_row !== want.second_row ||
          got.peak_centroid !== want.peak_centroid ||
          got.second_centroid !== want.second_centroid) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("column mismatch at %0t: peak_row %0d/%0d second_row %0d/%0d",
                   $realtime, want.peak_row, got.peak_row, want.second_row,
                   got.second_row);
          $display("  peak_centroid %0d/%0d second_centroid %0d/%0d (expected/actual)",
                   want.peak_centroid, got.peak_centroid, want.second_centroid,
                   got.second_centroid);
        end
      end
    endfunction

    function int pending_count();
      return expected_columns.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  column_scoreboard sb;
  bit sender_steady;
  bit receiver_steady;
  int hold_request;
  int hold_left;
  int stall_cycles;
  int random_items;

  stripe_peak_centroid_finder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result side: check at the rising edge, choose tready at the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= receiver_steady || ($urandom_range(99) >= 17);
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one pixel, with random idle cycles ahead of it, until accepted.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic first);
    while (!sender_steady && $urandom_range(99) < 17) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    in_tuser <= first;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(pix, first);
  endtask

  // Fills a column of n pixels with the chosen kind of content.
  function automatic void build_column(ref logic [PIX_W-1:0] px[$], input int n,
                                       input column_kind_t kind);
    int peaks, c0, c1, amp0, amp1, w0, w1, v, d, level;
    peaks = $urandom_range(1, 2);
    c0 = $urandom_range(0, n - 1);
    c1 = $urandom_range(0, n - 1);
    amp0 = $urandom_range(30, 255);
    amp1 = $urandom_range(30, 255);
    w0 = $urandom_range(0, 6);
    w1 = $urandom_range(0, 6);
    level = $urandom_range(1, 255);
    px.delete();
    for (int i = 0; i < n; i++) begin
      case (kind)
        COL_NOISE: begin
          v = $urandom_range(0, 255);
        end
        COL_FLAT: begin
          v = level;
        end
        COL_DARK: begin
          v = 0;
        end
        COL_BRIGHT: begin
          v = 255;
        end
        default: begin
          // Background noise plus one or two triangular stripes.
          v = $urandom_range(0, 24);
          d = (i > c0) ? i - c0 : c0 - i;
          if (d <= w0) begin
            v += amp0 * (w0 + 1 - d) / (w0 + 1);
          end
          d = (i > c1) ? i - c1 : c1 - i;
          if (peaks == 2 && d <= w1) begin
            v += amp1 * (w1 + 1 - d) / (w1 + 1);
          end
        end
      endcase
      px.insert(px.size(), (v > 255) ? 8'd255 : v[PIX_W-1:0]);
    end
  endfunction

  task automatic send_column(input int n, input column_kind_t kind, input bit mark_first);
    logic [PIX_W-1:0] px[$];
    build_column(px, n, kind);
    foreach (px[i]) begin
      send_pixel(px[i], mark_first && i == 0);
    end
  endtask

  // Stops offering pixels and waits until every expected column has come out.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tuser <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ROW_W-1:0] value);
    logic [CFG_DW-1:0] word;
    word = $urandom();
    word[ROW_W-1:0] = value;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, word);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic configure(input logic [ROW_W-1:0] start, input logic [ROW_W-1:0] count);
    drain_results();
    write_reg(REG_START_ROW, start);
    write_reg(REG_ROW_COUNT, count);
  endtask

  // A phase of well-formed columns mixed with cut-short and overlong ones.
  task automatic random_phase();
    int start, count, full, n, shape, ncols;
    column_kind_t kind;
    case ($urandom_range(0, 9))
      0: start = 0;
      1: start = 4095;
      2: start = 7;
      3: start = 4088;
      default: start = $urandom_range(7, 4088);
    endcase
    count = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
    configure(start[ROW_W-1:0], count[ROW_W-1:0]);
    full = 2 * HALF_TAPS + count;
    ncols = $urandom_range(2, 6);
    repeat (ncols) begin
      case ($urandom_range(0, 19))
        0, 1: kind = COL_NOISE;
        2: kind = COL_FLAT;
        3: kind = COL_DARK;
        default: kind = COL_STRIPE;
      endcase
      shape = $urandom_range(0, 99);
      if (shape < 10) begin
        n = $urandom_range(1, full - 1);
      end else if (shape < 20) begin
        n = full + $urandom_range(1, 5);
      end else begin
        n = full;
      end
      send_column(n, kind, 1'b1);
      random_items += (n < full) ? n : full;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    hold_request = 0;
    hold_left = 0;
    stall_cycles = 0;
    random_items = 0;
    sb = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // First column after reset with the reset settings and no column start flag.
    send_column(2 * HALF_TAPS + 120, COL_STRIPE, 1'b0);

    // Extreme pixels with rows wrapping below zero, then a flat column of ties.
    configure(12'd0, 12'd1);
    send_column(15, COL_BRIGHT, 1'b1);
    configure(12'd4095, 12'd2);
    send_column(16, COL_FLAT, 1'b1);

    // Zero row count: no center is examined and no result comes out.
    configure(12'd0, 12'd0);
    send_column(20, COL_NOISE, 1'b1);
    send_column(17, COL_STRIPE, 1'b1);

    // A longer column with rows wrapping past the top.
    configure(12'd4088, 12'd60);
    send_column(2 * HALF_TAPS + 60, COL_STRIPE, 1'b1);

    // Receiver holds off while short columns keep coming, so the block backs up.
    configure(12'd7, 12'd1);
    sender_steady = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (12) send_column(15, COL_STRIPE, 1'b1);
    sender_steady = 1'b0;

    // Random phases; the second one, if it is reached, runs with no idling on either side.
    for (int phase = 0; random_items < RANDOM_ITEMS; phase++) begin
      sender_steady = (phase == 1);
      receiver_steady = (phase == 1);
      random_phase();
    end
    sender_steady = 1'b0;
    receiver_steady = 1'b0;

    drain_results();
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
